### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and codes of the text console writer
// Request and result layouts, action and character codes, and the command
// codes that pass from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// one incoming request
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} item_t;

	// one result
	typedef struct packed {
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic [7:0] cell_char;
		logic [7:0] cell_color;
	} result_t;

	// request actions
	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// special characters and blank attribute after reset
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'd32;
	localparam logic [7:0] RESET_COLOR  = 8'd15;

	// decoded commands, front end to back end
	localparam logic [2:0] OP_NOP       = 3'd0;
	localparam logic [2:0] OP_CHAR      = 3'd1;
	localparam logic [2:0] OP_NEWLINE   = 3'd2;
	localparam logic [2:0] OP_BACKSPACE = 3'd3;
	localparam logic [2:0] OP_CLEAR     = 3'd4;
	localparam logic [2:0] OP_READ      = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} cmd_t;

endpackage

`default_nettype wire

### hw/rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front - request decode and command queue
// Turns each accepted request into a command code (out-of-range reads become
// no-ops) and holds up to two commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front
	import tcw_pkg::*;
#(
	parameter int NUM_COLUMNS = 80,
	parameter int NUM_ROWS    = 25
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item,
	input  wire logic  hold,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  wire logic  cmd_take
);

	logic [2:0] op_cls;
	logic       push_ok;
	logic       take_ok;
	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// classify the request
	always_comb begin
		op_cls = OP_NOP;
		case (item.action)
			ACT_PUT: begin
				if (item.char_code == CH_NEWLINE)
					op_cls = OP_NEWLINE;
				else if (item.char_code == CH_BACKSPACE)
					op_cls = OP_BACKSPACE;
				else
					op_cls = OP_CHAR;
			end
			ACT_CLEAR: begin
				op_cls = OP_CLEAR;
			end
			ACT_READ: begin
				if (({1'b0, item.read_row} < 6'(NUM_ROWS)) &&
				    ({1'b0, item.read_col} < 8'(NUM_COLUMNS)))
					op_cls = OP_READ;
			end
			default: begin
				op_cls = OP_NOP;
			end
		endcase
	end

	// queue handshake
	assign full      = (count_q == 2'd2) || hold;
	assign push_ok   = push && !full;
	assign cmd_valid = (count_q != 2'd0);
	assign take_ok   = cmd_take && cmd_valid;
	assign cmd       = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push_ok)
			slot_q[wr_ptr_q] <= '{op: op_cls, char_code: item.char_code,
			                      read_row: item.read_row, read_col: item.read_col};
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_ok)
				wr_ptr_q <= !wr_ptr_q;
			if (take_ok)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push_ok} - {1'b0, take_ok};
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back - command execution, screen memory and result register
// Keeps the cursor and the ring offset of rows, writes the cell memory and
// sweeps rows or the whole screen with blanks for scroll, clear and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back
	import tcw_pkg::*;
#(
	parameter int NUM_COLUMNS = 80,
	parameter int NUM_ROWS    = 25
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       cmd_valid,
	input  wire cmd_t       cmd,
	output logic            cmd_take,
	output logic            init_busy,
	output logic            res_valid,
	output result_t         res,
	input  wire logic       res_pop
);

	localparam int CELLS = NUM_COLUMNS * NUM_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(NUM_COLUMNS + 1);
	localparam int RW    = $clog2(NUM_ROWS);
	localparam int RW1   = RW + 1;

	localparam logic [CW-1:0]  END_COL   = CW'(NUM_COLUMNS);
	localparam logic [CW-1:0]  LAST_COL  = CW'(NUM_COLUMNS - 1);
	localparam logic [RW-1:0]  LAST_ROW  = RW'(NUM_ROWS - 1);
	localparam logic [RW1-1:0] ROWS_EXT  = RW1'(NUM_ROWS);
	localparam logic [AW-1:0]  COLS_AW   = AW'(NUM_COLUMNS);
	localparam logic [AW-1:0]  ROW_SPAN  = AW'(NUM_COLUMNS - 1);
	localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_BS    = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	// memory address of a logical row and column through the row ring
	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] top,
	                                            input logic [RW-1:0] row,
	                                            input logic [CW-1:0] col);
		logic [RW1-1:0] sum;
		logic [RW-1:0]  phys;
		sum = {1'b0, top} + {1'b0, row};
		if (sum >= ROWS_EXT)
			sum = sum - ROWS_EXT;
		phys = sum[RW-1:0];
		return AW'(AW'(phys) * COLS_AW + AW'(col));
	endfunction

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [RW-1:0] top_q, top_d;
	logic [7:0]    color_q;
	logic [AW-1:0] sweep_addr_q, sweep_addr_d;
	logic [AW-1:0] sweep_end_q, sweep_end_d;
	logic [7:0]    sweep_color_q, sweep_color_d;
	logic          emit_after_q, emit_after_d;
	logic          init_q;
	logic          sweep_done;
	logic          res_valid_q;
	result_t       res_q;

	logic [15:0]   mem [CELLS];
	logic [15:0]   rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;

	logic [RW-1:0] row_sel;
	logic [CW-1:0] col_sel;
	logic [AW-1:0] pos_addr;
	logic [AW-1:0] row_base;
	logic          out_free;
	logic          nl;
	logic          nl_emit;
	logic          emit;
	logic [7:0]    emit_char;
	logic [7:0]    emit_color;

	assign out_free  = !res_valid_q || res_pop;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign init_busy = init_q;

	// cell under the cursor, or the addressed cell of a read
	always_comb begin
		if (state_q == ST_IDLE && cmd.op == OP_READ) begin
			row_sel = RW'(cmd.read_row);
			col_sel = CW'(cmd.read_col);
		end else begin
			row_sel = row_q;
			col_sel = col_q;
		end
	end

	assign pos_addr = cell_addr(top_q, row_sel, col_sel);
	assign row_base = AW'(AW'(top_q) * COLS_AW);

	// sequencer
	always_comb begin
		state_d       = state_q;
		col_d         = col_q;
		row_d         = row_q;
		top_d         = top_q;
		sweep_addr_d  = sweep_addr_q;
		sweep_end_d   = sweep_end_q;
		sweep_color_d = sweep_color_q;
		emit_after_d  = emit_after_q;
		sweep_done    = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = pos_addr;
		mem_wdata     = {color_q, CH_SPACE};
		mem_re        = 1'b0;
		cmd_take      = 1'b0;
		nl            = 1'b0;
		nl_emit       = 1'b0;
		emit          = 1'b0;
		emit_char     = 8'd0;
		emit_color    = 8'd0;

		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					case (cmd.op)
						OP_CHAR: begin
							if (col_q == END_COL) begin
								// wrap first, the character stays queued
								nl = 1'b1;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = {color_q, cmd.char_code};
								col_d     = col_q + CW'(1);
								emit      = 1'b1;
								cmd_take  = 1'b1;
							end
						end
						OP_NEWLINE: begin
							nl       = 1'b1;
							nl_emit  = 1'b1;
							cmd_take = 1'b1;
						end
						OP_BACKSPACE: begin
							cmd_take = 1'b1;
							if (col_q == '0) begin
								if (row_q != '0) begin
									row_d = row_q - RW'(1);
									col_d = LAST_COL;
								end
							end else begin
								col_d = col_q - CW'(1);
							end
							state_d = ST_BS;
						end
						OP_CLEAR: begin
							cmd_take      = 1'b1;
							col_d         = '0;
							row_d         = '0;
							top_d         = '0;
							sweep_addr_d  = '0;
							sweep_end_d   = LAST_CELL;
							sweep_color_d = color_q;
							emit_after_d  = 1'b1;
							state_d       = ST_SWEEP;
						end
						OP_READ: begin
							cmd_take = 1'b1;
							mem_re   = 1'b1;
							state_d  = ST_READ;
						end
						default: begin
							cmd_take = 1'b1;
							emit     = 1'b1;
						end
					endcase

					// newline: next row, or turn the ring and blank the old top row
					if (nl) begin
						col_d = '0;
						if (row_q != LAST_ROW) begin
							row_d = row_q + RW'(1);
							emit  = nl_emit;
						end else begin
							top_d         = (top_q == LAST_ROW) ? '0 : top_q + RW'(1);
							sweep_addr_d  = row_base;
							sweep_end_d   = row_base + ROW_SPAN;
							sweep_color_d = color_q;
							emit_after_d  = nl_emit;
							state_d       = ST_SWEEP;
						end
					end
				end
			end
			ST_SWEEP: begin
				mem_we       = 1'b1;
				mem_waddr    = sweep_addr_q;
				mem_wdata    = {sweep_color_q, CH_SPACE};
				sweep_addr_d = sweep_addr_q + AW'(1);
				if (sweep_addr_q == sweep_end_q) begin
					sweep_done = 1'b1;
					state_d    = emit_after_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_BS: begin
				// blank the cell the cursor moved back onto
				mem_we  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_READ: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_char  = rd_q[7:0];
					emit_color = rd_q[15:8];
					state_d    = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// screen memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[pos_addr];
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit)
			res_q <= '{cursor_col: 7'(col_d), cursor_row: 5'(row_d),
			           cell_char: emit_char, cell_color: emit_color};
	end

	// control state; reset starts a blanking pass over the whole screen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			col_q         <= '0;
			row_q         <= '0;
			top_q         <= '0;
			color_q       <= RESET_COLOR;
			sweep_addr_q  <= '0;
			sweep_end_q   <= LAST_CELL;
			sweep_color_q <= RESET_COLOR;
			emit_after_q  <= 1'b0;
			init_q        <= 1'b1;
			res_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			col_q         <= col_d;
			row_q         <= row_d;
			top_q         <= top_d;
			sweep_addr_q  <= sweep_addr_d;
			sweep_end_q   <= sweep_end_d;
			sweep_color_q <= sweep_color_d;
			emit_after_q  <= emit_after_d;
			if (cfg_wr_en)
				color_q <= cfg_wr_data;
			if (sweep_done)
				init_q <= 1'b0;
			if (emit)
				res_valid_q <= 1'b1;
			else if (res_pop)
				res_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer - character-cell text console with cursor
// Front end decodes requests into a two-deep command queue; back end runs
// them against the screen memory and hands results out through a register.
// ----------------------------------------------------------------------------
// After reset the block blanks all NUM_COLUMNS*NUM_ROWS cells with full held
// high; configuration writes are taken meanwhile. Once running, the back end
// handles a printable character, a newline without scroll or an ignored
// request straight from its idle state; a read goes through a registered
// memory read, a backspace through cursor step, blank and result, and a
// newline that scrolls blanks the old top row through the single memory write
// port, one cell a cycle. A clear blanks the whole screen the same way. A
// character written past the line end first wraps, which scrolls the screen
// when the cursor is on the last row.
// The queue in front holds up to two requests for the back end.
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int NUM_COLUMNS = 80,
	parameter int NUM_ROWS    = 25
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire item_t      item,
	output logic            empty,
	input  wire logic       pop,
	output result_t         result,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data
);

	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_take;
	logic    init_busy;
	logic    res_valid;
	logic    res_pop;

	assign empty   = !res_valid;
	assign res_pop = pop && res_valid;

	// request decode and queue
	tcw_front #(
		.NUM_COLUMNS(NUM_COLUMNS),
		.NUM_ROWS   (NUM_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.hold     (init_busy),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	// execution and screen memory
	tcw_back #(
		.NUM_COLUMNS(NUM_COLUMNS),
		.NUM_ROWS   (NUM_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take),
		.init_busy  (init_busy),
		.res_valid  (res_valid),
		.res        (result),
		.res_pop    (res_pop)
	);

endmodule

`default_nettype wire

### hw/rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker - port-level checks of the text console writer
// Watches the result side: results hold until taken and the reported cursor
// stays on the screen.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker
	import tcw_pkg::*;
#(
	parameter int NUM_COLUMNS = 80,
	parameter int NUM_ROWS    = 25
) (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    empty,
	input wire logic    pop,
	input wire result_t result
);

	// a waiting result is not withdrawn
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before pop");

	// a waiting result does not change
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result))
		else $error("result changed while waiting");

	// cursor row is always on the screen
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, result.cursor_row} < 6'(NUM_ROWS)))
		else $error("cursor row off screen");

	// cursor column never beyond the past-end position
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (NUM_COLUMNS < 128) |-> ({1'b0, result.cursor_col} <= 8'(NUM_COLUMNS)))
		else $error("cursor column beyond line end");

endmodule

bind text_console_writer tcw_checker #(
	.NUM_COLUMNS(NUM_COLUMNS),
	.NUM_ROWS   (NUM_ROWS)
) u_tcw_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.empty (empty),
	.pop   (pop),
	.result(result)
);

`default_nettype wire

### tb/sv/console_checker.sv
// ----------------------------------------------------------------------------
// console_checker - result checker for the text console writer
// Watches the request, result and configuration channels, keeps its own copy
// of the screen, cursor and colour, and compares every result taken by the
// receiver with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module console_checker
	import tcw_pkg::*;
#(
	parameter int NUM_COLUMNS = 80,
	parameter int NUM_ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  item_t      item,
	input  logic       empty,
	input  logic       pop,
	input  result_t    result,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	output int         fail_count,
	output int         pending
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELL_COUNT = NUM_COLUMNS * NUM_ROWS;

	// predicted console state
	logic [15:0] scr_mem [CELL_COUNT];
	int unsigned cur_col;
	int unsigned cur_row;
	int unsigned ring_base;
	logic [7:0]  text_attr;

	// predicted results still to come out
	result_t     expected_results [$];

	// physical cell address of a screen position, rows turn as a ring
	function automatic int unsigned cell_addr(int unsigned r, int unsigned c);
		return ((ring_base + r) % NUM_ROWS) * NUM_COLUMNS + c;
	endfunction

	// every cell blank, cursor and ring back to the origin
	function automatic void wipe_screen();
		for (int i = 0; i < CELL_COUNT; i++) begin
			scr_mem[i] = {text_attr, CH_SPACE};
		end
		cur_col   = 0;
		cur_row   = 0;
		ring_base = 0;
	endfunction

	// next row, or scroll and blank the new bottom row
	function automatic void line_feed();
		cur_col = 0;
		if (cur_row < NUM_ROWS - 1) begin
			cur_row++;
		end else begin
			ring_base = (ring_base + 1) % NUM_ROWS;
			for (int c = 0; c < NUM_COLUMNS; c++) begin
				scr_mem[cell_addr(NUM_ROWS - 1, c)] = {text_attr, CH_SPACE};
			end
		end
	endfunction

	// cursor back one cell, wrapping to the row above, then blank it
	function automatic void step_back();
		if (cur_col == 0) begin
			if (cur_row > 0) begin
				cur_row--;
				cur_col = NUM_COLUMNS;
			end else begin
				cur_col = 1;
			end
		end
		cur_col--;
		scr_mem[cell_addr(cur_row, cur_col)] = {text_attr, CH_SPACE};
	endfunction

	// apply one request to the console and work out its result
	function automatic result_t console_step(item_t req);
		result_t     res;
		logic [15:0] word;
		res = '0;
		case (req.action)
			ACT_PUT: begin
				if (req.char_code == CH_NEWLINE) begin
					line_feed();
				end else if (req.char_code == CH_BACKSPACE) begin
					step_back();
				end else begin
					// past the line end a newline comes first
					if (cur_col >= NUM_COLUMNS) begin
						line_feed();
					end
					scr_mem[cell_addr(cur_row, cur_col)] = {text_attr, req.char_code};
					cur_col++;
				end
			end
			ACT_CLEAR: begin
				wipe_screen();
			end
			ACT_READ: begin
				// cells off the screen read as zero
				if (req.read_row < NUM_ROWS && req.read_col < NUM_COLUMNS) begin
					word = scr_mem[cell_addr(req.read_row, req.read_col)];
					res.cell_char  = word[7:0];
					res.cell_color = word[15:8];
				end
			end
			default: begin
			end
		endcase
		res.cursor_col = cur_col[6:0];
		res.cursor_row = cur_row[4:0];
		return res;
	endfunction

	// one field of a result against its prediction
	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// follow the channels on every clock edge
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			text_attr = RESET_COLOR;
			wipe_screen();
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_wr_en) begin
				text_attr = cfg_wr_data;
			end
			if (push && !full) begin
				expected_results.push_back(console_step(item));
			end
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: col %0d row %0d",
						result.cursor_col, result.cursor_row);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("cursor_col", want.cursor_col, result.cursor_col);
					check_field("cursor_row", want.cursor_row, result.cursor_row);
					check_field("cell_char", want.cell_char, result.cell_char);
					check_field("cell_color", want.cell_color, result.cell_color);
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - top level for the text console writer
// Drives a directed opening and then phases of random typing with varying
// mixes of characters, newlines, backspaces, reads and clears, changing the
// text colour between phases. Both queue sides idle at random. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
	import tcw_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS = 80;
	localparam int ROWS = 25;

	// request action with no effect on the console
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// longest quiet stretch is a full clear plus a long receiver stall
	localparam int STALL_LIMIT = 10000;
	localparam int TAIL_CYCLES = 100;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	item_t      item;
	logic       empty;
	logic       pop;
	result_t    result;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	int         fail_count;
	int         pending;
	int         idle_cycles;
	logic       steady_flow;

	text_console_writer #(
		.NUM_COLUMNS(COLS),
		.NUM_ROWS   (ROWS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	console_checker #(
		.NUM_COLUMNS(COLS),
		.NUM_ROWS   (ROWS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_gap();
		int unsigned pick;
		if (steady_flow) begin
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			return 0;
		end else if (pick < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t mk_req(logic [1:0] act, logic [7:0] ch, logic [4:0] r,
		logic [6:0] c);
		item_t req;
		req.action    = act;
		req.char_code = ch;
		req.read_row  = r;
		req.read_col  = c;
		return req;
	endfunction

	// random request; nl, bs and rd are percentages of newline, backspace and read
	function automatic item_t make_request(int nl, int bs, int rd);
		item_t       req;
		int unsigned pick;
		int unsigned sub;
		req.char_code = 8'($urandom);
		req.read_row  = 5'($urandom);
		req.read_col  = 7'($urandom);
		pick = $urandom_range(0, 999);
		if (pick < 5) begin
			req.action = ACT_CLEAR;
		end else if (pick < 15) begin
			req.action = ACT_UNUSED;
		end else if (pick < 15 + rd * 10) begin
			req.action = ACT_READ;
			// mostly cells on the screen, some anywhere in the field range
			if ($urandom_range(0, 99) < 85) begin
				req.read_row = 5'($urandom_range(0, ROWS - 1));
				req.read_col = 7'($urandom_range(0, COLS - 1));
			end
		end else begin
			req.action = ACT_PUT;
			sub = $urandom_range(0, 99);
			if (sub < nl) begin
				req.char_code = CH_NEWLINE;
			end else if (sub < nl + bs) begin
				req.char_code = CH_BACKSPACE;
			end
		end
		return req;
	endfunction

	// hand one request over, holding push through back-to-back requests
	task automatic send_request(input item_t req);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= req;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// stop requests and wait until every result is out
	task automatic finish_phase();
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// colour write, only while the block is idle
	task automatic set_color(input logic [7:0] color);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= color;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic type_phase(input int count, input int nl, input int bs, input int rd);
		for (int i = 0; i < count; i++) begin
			send_request(make_request(nl, bs, rd));
		end
		finish_phase();
	endtask

	// receiver side with random stalls
	initial begin : result_side
		int gap;
		wait (arst_n);
		forever begin
			gap = idle_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	// watchdog on cycles with no request or result taken
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		item        = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 8'h00;
		steady_flow = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening under the reset colour
		send_request(mk_req(ACT_READ, 8'h00, 5'd0, 7'd0));
		send_request(mk_req(ACT_READ, 8'h00, 5'(ROWS - 1), 7'(COLS - 1)));
		send_request(mk_req(ACT_READ, 8'h00, 5'(ROWS), 7'd0));
		send_request(mk_req(ACT_READ, 8'hFF, 5'd0, 7'(COLS)));
		send_request(mk_req(ACT_READ, 8'hFF, 5'h1F, 7'h7F));
		send_request(mk_req(ACT_UNUSED, 8'hFF, 5'h1F, 7'h7F));
		// backspace at the origin stays there
		send_request(mk_req(ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		send_request(mk_req(ACT_PUT, 8'h00, 5'd0, 7'd0));
		send_request(mk_req(ACT_PUT, 8'hFF, 5'd0, 7'd0));
		send_request(mk_req(ACT_PUT, CH_NEWLINE, 5'd0, 7'd0));
		// backspace at column 0 wraps to the end of the row above
		send_request(mk_req(ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		send_request(mk_req(ACT_PUT, 8'h78, 5'd0, 7'd0));
		// backspace from past the line end
		send_request(mk_req(ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		send_request(mk_req(ACT_PUT, 8'h79, 5'd0, 7'd0));
		// character past the line end wraps first
		send_request(mk_req(ACT_PUT, 8'h7A, 5'd0, 7'd0));
		send_request(mk_req(ACT_READ, 8'h00, 5'd0, 7'd0));
		send_request(mk_req(ACT_READ, 8'h00, 5'd0, 7'(COLS - 1)));
		send_request(mk_req(ACT_READ, 8'h00, 5'd1, 7'd0));
		send_request(mk_req(ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		send_request(mk_req(ACT_READ, 8'h00, 5'd1, 7'd0));
		send_request(mk_req(ACT_CLEAR, 8'h00, 5'd0, 7'd0));
		send_request(mk_req(ACT_READ, 8'h00, 5'd0, 7'd1));
		finish_phase();

		// long lines to reach the wrap, darkest colour
		set_color(8'h00);
		type_phase(200, 1, 3, 15);
		// newline heavy to scroll, brightest colour
		set_color(8'hFF);
		type_phase(200, 25, 5, 15);
		// backspace heavy with no idling
		steady_flow = 1'b1;
		set_color(8'($urandom_range(1, 254)));
		type_phase(200, 5, 35, 15);
		steady_flow = 1'b0;
		set_color(8'($urandom_range(1, 254)));
		type_phase(200, 8, 8, 25);
		// read heavy
		set_color(8'($urandom_range(1, 254)));
		type_phase(200, 10, 5, 50);
		set_color(8'($urandom_range(1, 254)));
		type_phase(200, 3, 10, 15);

		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
